@@ rtl/shs_pkg.sv @@
package shs_pkg;

   // sequencer states, one-hot
   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_PAD  = 5'b00010,
      S_COMP = 5'b00100,
      S_ADD  = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   localparam int unsigned WordBits   = 32;
   localparam int unsigned NumRounds  = 64;
   localparam int unsigned BlockWords = 16;
   localparam int unsigned ChainWords = 8;
   localparam int unsigned LenPos     = 56;

   localparam logic [7:0] PadByte = 8'h80;

   // round constants
   localparam logic [31:0] RoundK [NumRounds] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // initial chaining values
   localparam logic [31:0] InitH [ChainWords] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

endpackage

@@ rtl/sha256_stream_hasher.sv @@
// a byte is taken only while idle; a byte that fills the block starts a compression of
// 64 rounds on the shared round unit plus the chaining add
// end mark: one pad byte per cycle up to byte 63 of the block and a compression, twice
// if the length does not fit, then 8 digest transactions, one per cycle when not stalled
// reset (synchronous, active high) loads the initial chaining values, clears the count
// and leaves the block idle and ready
module sha256_stream_hasher
   import shs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   state_type     state_ff, state_in;
   state_type     ret_ff, ret_in;
   logic [63:0]   count_ff, count_in;
   logic [31:0]   h_ff [ChainWords];
   logic [31:0]   h_in [ChainWords];
   logic [31:0]   v_ff [ChainWords];
   logic [31:0]   v_in [ChainWords];
   logic [31:0]   w_ff [BlockWords];
   logic [31:0]   w_in [BlockWords];
   logic [5:0]    round_ff, round_in;
   logic [5:0]    pad_pos_ff, pad_pos_in;
   logic          pad_first_ff, pad_first_in;
   logic          len_ok_ff, len_ok_in;
   logic [2:0]    idx_ff, idx_in;

   logic          wr_en;
   logic [5:0]    wr_idx;
   logic [7:0]    wr_byte;
   logic [31:0]   big0, big1, ch, maj, t1, t2, sig0, sig1, w_new;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (WordBits - n));
   endfunction

   // big-endian byte of the bit length
   function automatic logic [7:0] len_byte(input logic [63:0] cnt, input logic [2:0] sel);
      logic [63:0] bits;
      bits = {cnt[60:0], 3'b000};
      len_byte = bits[8 * (7 - sel) +: 8];
   endfunction

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = (state_ff == S_OUT);
   assign rsp_digest_word = h_ff[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == 3'd7);

   // shared round unit and schedule update
   always_comb begin
      big1  = rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25);
      ch    = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1    = v_ff[7] + big1 + ch + RoundK[round_ff] + w_ff[0];
      big0  = rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22);
      maj   = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2    = big0 + maj;
      sig0  = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      sig1  = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      w_new = sig1 + w_ff[9] + sig0 + w_ff[0];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      count_in     = count_ff;
      h_in         = h_ff;
      v_in         = v_ff;
      round_in     = round_ff;
      pad_pos_in   = pad_pos_ff;
      pad_first_in = pad_first_ff;
      len_ok_in    = len_ok_ff;
      idx_in       = idx_ff;
      wr_en        = 1'b0;
      wr_idx       = count_ff[5:0];
      wr_byte      = req_data_byte;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_has_byte) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 64'd1;
               end
               if (req_end_of_message) begin
                  pad_pos_in   = count_in[5:0];
                  pad_first_in = 1'b1;
                  len_ok_in    = (count_in[5:0] < 6'(LenPos));
               end
               if (req_has_byte && (count_ff[5:0] == 6'd63)) begin
                  state_in = S_COMP;
                  v_in     = h_ff;
                  round_in = '0;
                  ret_in   = req_end_of_message ? S_PAD : S_IDLE;
               end else if (req_end_of_message) begin
                  state_in = S_PAD;
               end
            end
         end
         S_PAD: begin
            wr_en  = 1'b1;
            wr_idx = pad_pos_ff;
            if (pad_first_ff) begin
               wr_byte = PadByte;
            end else if (len_ok_ff && (pad_pos_ff >= 6'(LenPos))) begin
               wr_byte = len_byte(count_ff, pad_pos_ff[2:0]);
            end else begin
               wr_byte = 8'h00;
            end
            pad_first_in = 1'b0;
            pad_pos_in   = pad_pos_ff + 6'd1;
            if (pad_pos_ff == 6'd63) begin
               state_in  = S_COMP;
               v_in      = h_ff;
               round_in  = '0;
               ret_in    = len_ok_ff ? S_OUT : S_PAD;
               len_ok_in = 1'b1;
            end
         end
         S_COMP: begin
            v_in[7]  = v_ff[6];
            v_in[6]  = v_ff[5];
            v_in[5]  = v_ff[4];
            v_in[4]  = v_ff[3] + t1;
            v_in[3]  = v_ff[2];
            v_in[2]  = v_ff[1];
            v_in[1]  = v_ff[0];
            v_in[0]  = t1 + t2;
            round_in = round_ff + 6'd1;
            if (round_ff == 6'(NumRounds - 1)) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            for (int i = 0; i < ChainWords; i++) begin
               h_in[i] = h_ff[i] + v_ff[i];
            end
            idx_in   = '0;
            state_in = ret_ff;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  h_in     = InitH;
                  count_in = '0;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // block buffer: byte writes while gathering, window shift while compressing
   always_comb begin
      w_in = w_ff;
      if (state_ff == S_COMP) begin
         for (int j = 0; j < BlockWords - 1; j++) begin
            w_in[j] = w_ff[j + 1];
         end
         w_in[BlockWords - 1] = w_new;
      end else if (wr_en) begin
         w_in[wr_idx[5:2]][8 * (3 - wr_idx[1:0]) +: 8] = wr_byte;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         h_ff     <= InitH;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         h_ff     <= h_in;
         idx_ff   <= idx_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      ret_ff       <= ret_in;
      v_ff         <= v_in;
      w_ff         <= w_in;
      round_ff     <= round_in;
      pad_pos_ff   <= pad_pos_in;
      pad_first_ff <= pad_first_in;
      len_ok_ff    <= len_ok_in;
   end

endmodule

@@ tb/sha256_stream_hasher_test.sv @@
`timescale 1ns / 100ps

module sha256_stream_hasher_test;

   localparam int unsigned CycleLimit  = 400000;
   localparam int unsigned DrainCycles = 200;
   localparam int unsigned StimItems   = 180;
   localparam int unsigned MaxReports  = 10;
   localparam int unsigned LenField    = 56;
   localparam logic [7:0]  PadMark     = 8'h80;

   localparam logic [31:0] RoundConst [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] ChainInit [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef struct packed {
      logic [7:0] data;
      logic       has_byte;
      logic       end_mark;
   } msg_item_type;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PERIODIC
   } stall_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_has_byte = 1'b0;
   logic        req_end_of_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   // hash state mirror
   logic [31:0] chain_h [8];
   logic [7:0]  blk_buf [64];
   logic [63:0] msg_len;

   msg_item_type    pending_q [$];
   digest_word_type digest_q [$];
   msg_item_type    cur_item;
   int unsigned     stim_items;
   int unsigned     error_count;
   int unsigned     cycle_count;
   int unsigned     gap_left;
   int unsigned     burst_left;
   stall_mode_type  stall_mode;

   sha256_stream_hasher dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_has_byte       (req_has_byte),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word)
   );

   always #5 clock = ~clock;

   function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // one 64-round compression of the block buffer into the chaining words
   function automatic void sha_compress();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] s0, s1, t1, t2, big0, big1, ch, maj;
      int          i;
      for (i = 0; i < 16; i++) begin
         w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
      end
      for (i = 16; i < 64; i++) begin
         s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = s1 + w[i-7] + s0 + w[i-16];
      end
      for (i = 0; i < 8; i++) begin
         v[i] = chain_h[i];
      end
      for (i = 0; i < 64; i++) begin
         big1 = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
         ch   = (v[4] & v[5]) ^ (~v[4] & v[6]);
         t1   = v[7] + big1 + ch + RoundConst[i] + w[i];
         big0 = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
         maj  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
         t2   = big0 + maj;
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (i = 0; i < 8; i++) begin
         chain_h[i] = chain_h[i] + v[i];
      end
   endfunction

   function automatic void clear_hash_state();
      int i;
      for (i = 0; i < 8; i++) begin
         chain_h[i] = ChainInit[i];
      end
      msg_len = '0;
   endfunction

   // absorb one accepted transaction, queue the digest on an end mark
   function automatic void predict_digest(input msg_item_type it);
      int              pos;
      int              i;
      logic [63:0]     bit_len;
      digest_word_type dw;
      if (it.has_byte) begin
         blk_buf[msg_len[5:0]] = it.data;
         msg_len = msg_len + 64'd1;
         if (msg_len[5:0] == 6'd0) begin
            sha_compress();
         end
      end
      if (!it.end_mark) begin
         return;
      end
      // padding: marker byte, zero fill, big-endian bit length
      pos = msg_len[5:0];
      bit_len = msg_len << 3;
      blk_buf[pos] = PadMark;
      pos = pos + 1;
      if (pos > LenField) begin
         while (pos < 64) begin
            blk_buf[pos] = 8'h00;
            pos = pos + 1;
         end
         sha_compress();
         pos = 0;
      end
      while (pos < LenField) begin
         blk_buf[pos] = 8'h00;
         pos = pos + 1;
      end
      for (i = 0; i < 8; i++) begin
         blk_buf[LenField + i] = bit_len[63 - 8*i -: 8];
      end
      sha_compress();
      for (i = 0; i < 8; i++) begin
         dw.word  = chain_h[i];
         dw.index = 3'(i);
         dw.last  = (i == 7);
         digest_q.push_back(dw);
      end
      clear_hash_state();
   endfunction

   task automatic flag_mismatch(input string why, input digest_word_type want,
                                input digest_word_type got);
      error_count++;
      if (error_count <= MaxReports) begin
         $display("%0t %s: expected word %h index %0d last %0b, got word %h index %0d last %0b",
                  $realtime, why, want.word, want.index, want.last,
                  got.word, got.index, got.last);
      end
   endtask

   task automatic push_item(input logic [7:0] data, input logic has_byte,
                            input logic end_mark);
      msg_item_type it;
      it.data     = data;
      it.has_byte = has_byte;
      it.end_mark = end_mark;
      pending_q.push_back(it);
   endtask

   // one message of random content, with ignored filler mixed in
   task automatic add_message(input int unsigned len);
      int unsigned k;
      logic        join_tail;
      join_tail = (len > 0) && ($urandom_range(0, 1) == 1);
      for (k = 0; k < len; k++) begin
         if ($urandom_range(0, 9) == 0) begin
            push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            stim_items++;
         end
         push_item(8'($urandom_range(0, 255)), 1'b1, join_tail && (k == len - 1));
         stim_items++;
      end
      if (!join_tail) begin
         push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
         stim_items++;
      end
   endtask

   // cycle count and timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("sha256_stream_hasher: mismatch");
         $finish;
      end
   end

   // request driver: bursts of transactions separated by random gaps
   always @(posedge clock) begin
      logic taken;
      logic next_valid;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
         burst_left = 0;
      end else begin
         taken = req_valid && !req_stall;
         if (taken) begin
            predict_digest(cur_item);
         end
         next_valid = req_valid && !taken;
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_q.size() > 0) begin
               cur_item = pending_q.pop_front();
               next_valid = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 30);
                  gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
         req_valid <= next_valid;
         req_data_byte <= cur_item.data;
         req_has_byte <= cur_item.has_byte;
         req_end_of_message <= cur_item.end_mark;
      end
   end

   // response stall pattern with a randomly picked mode
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_mode = STALL_NONE;
      end else begin
         if (cycle_count % 64 == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 2));
         end
         case (stall_mode)
            STALL_NONE: begin
               rsp_stall <= 1'b0;
            end
            STALL_RANDOM: begin
               rsp_stall <= 1'($urandom_range(0, 1));
            end
            default: begin
               rsp_stall <= (cycle_count % 8) < 3;
            end
         endcase
      end
   end

   // response monitor
   always @(posedge clock) begin
      digest_word_type got;
      digest_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.word  = rsp_digest_word;
         got.index = rsp_word_index;
         got.last  = rsp_last_word;
         if (digest_q.size() == 0) begin
            flag_mismatch("digest word with none pending", '0, got);
         end else begin
            want = digest_q.pop_front();
            if (got.word !== want.word || got.index !== want.index
                || got.last !== want.last) begin
               flag_mismatch("digest word differs", want, got);
            end
         end
      end
   end

   initial begin
      int unsigned pick;
      clear_hash_state();
      stim_items = 0;
      error_count = 0;
      cycle_count = 0;
      cur_item = '0;

      // directed: ignored items, empty message, single bytes, short text
      push_item(8'h5a, 1'b0, 1'b0);
      push_item(8'h00, 1'b0, 1'b1);
      push_item(8'h00, 1'b1, 1'b1);
      push_item(8'hff, 1'b1, 1'b0);
      push_item(8'hff, 1'b0, 1'b0);
      push_item(8'hff, 1'b0, 1'b1);
      push_item(8'h61, 1'b1, 1'b0);
      push_item(8'h62, 1'b1, 1'b0);
      push_item(8'h63, 1'b1, 1'b1);
      push_item(8'h00, 1'b0, 1'b1);
      stim_items = 10;

      // random messages, many near the block and length-field boundaries
      while (stim_items < StimItems) begin
         pick = $urandom_range(0, 19);
         if (pick < 11) begin
            add_message($urandom_range(0, 12));
         end else if (pick < 17) begin
            add_message($urandom_range(52, 66));
         end else begin
            add_message($urandom_range(0, 40));
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // wait for all transactions and digests, then let the block settle
      while (pending_q.size() != 0 || req_valid || digest_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);

      if (error_count == 0 && digest_q.size() == 0) begin
         $display("sha256_stream_hasher: match");
      end else begin
         $display("sha256_stream_hasher: mismatch");
      end
      $finish;
   end

endmodule
